// ===== sv/wmre_pkg.sv =====
// Shared types and constants for the waveform min/max/RMS envelope block.
`default_nettype none

package wmre_pkg;

  typedef logic [2:0] state_t;

  localparam state_t ST_IDLE = 3'd0;
  localparam state_t ST_SQ   = 3'd1;
  localparam state_t ST_ACC  = 3'd2;
  localparam state_t ST_DIV  = 3'd3;
  localparam state_t ST_SQRT = 3'd4;
  localparam state_t ST_FIN  = 3'd5;

  typedef logic op_t;

  localparam op_t OP_DIV  = 1'b0;
  localparam op_t OP_SQRT = 1'b1;

  localparam int WIN_LEN_RESET = 200;
  localparam int INDEX_BITS    = 32;

endpackage

`default_nettype wire

// ===== sv/wmre_cmp_sub.sv =====
// Shared compare-and-subtract step for restoring division and square root.
`default_nettype none

module wmre_cmp_sub #(
  parameter int COUNT_BITS = 16,
  parameter int ROOT_BITS  = 23,
  parameter int REM_BITS   = 26
) (
  input  wire wmre_pkg::op_t         op,
  input  wire logic [REM_BITS-1:0]   rem_in,
  input  wire logic [1:0]            shift_in,
  input  wire logic [COUNT_BITS-1:0] divisor,
  input  wire logic [ROOT_BITS-1:0]  root,
  output logic      [REM_BITS-1:0]   rem_out,
  output logic                       ge
);

  logic [REM_BITS-1:0] cand;
  logic [REM_BITS-1:0] sub;
  logic [REM_BITS:0]   diff;

  always_comb begin
    if (op == wmre_pkg::OP_SQRT) begin
      cand = {rem_in[REM_BITS-3:0], shift_in};
      sub  = REM_BITS'({root, 2'b01});
    end else begin
      cand = {rem_in[REM_BITS-2:0], shift_in[1]};
      sub  = REM_BITS'(divisor);
    end
    diff    = {1'b0, cand} - {1'b0, sub};
    ge      = ~diff[REM_BITS];
    rem_out = ge ? diff[REM_BITS-1:0] : cand;
  end

endmodule

`default_nettype wire

// ===== sv/waveform_min_max_rms_envelope.sv =====
// Top level: windowed min/max/RMS envelope of a mono fixed-point audio stream.
//
// Input channel: in_sample (signed, SAMPLE_FRAC_BITS fraction bits) and
// in_end_of_stream transfer when in_valid is high and in_stall is low. Each
// sample is clamped to +/-1.0 and folded into the current window.
// Result channel: one result per closed window, held on the out_ ports while
// out_stall is high. A window closes when it holds window_length samples (0
// acts as 1) or on an end-of-stream sample, which also restarts the index.
// cfg_write loads cfg_data into window_length; write only while idle.
// Flow: a sample goes through the square and accumulate states. A closing
// sample also runs a restoring divide of the square sum by the
// count, 2*ceil(SUM_W/2) steps, then a digit-by-digit square root,
// ceil(SUM_W/2) steps, on one shared compare-subtract unit, with
// SUM_W = min(64, 2*SAMPLE_FRAC_BITS+COUNT_BITS).
// in_stall is high for the whole time a sample is being worked on.
// The result register frees the engine; a second result waits in the final
// step until out_stall drops.
// Reset (rst_n low, synchronous) sets window_length to 200, empties the
// window and restarts the index at zero.
`default_nettype none

module waveform_min_max_rms_envelope #(
  parameter int COUNT_BITS       = 16,
  parameter int SAMPLE_FRAC_BITS = 15
) (
  input  wire  logic                                 clk,
  input  wire  logic                                 rst_n,
  input  wire  logic                                 cfg_write,
  input  wire  logic [COUNT_BITS-1:0]                cfg_data,
  input  wire  logic                                 in_valid,
  output logic                                       in_stall,
  input  wire  logic signed [SAMPLE_FRAC_BITS+2:0]   in_sample,
  input  wire  logic                                 in_end_of_stream,
  output logic                                       out_valid,
  input  wire  logic                                 out_stall,
  output logic [wmre_pkg::INDEX_BITS-1:0]            out_window_index,
  output logic signed [SAMPLE_FRAC_BITS+1:0]         out_min_amplitude,
  output logic signed [SAMPLE_FRAC_BITS+1:0]         out_max_amplitude,
  output logic [SAMPLE_FRAC_BITS:0]                  out_rms_amplitude,
  output logic [COUNT_BITS-1:0]                      out_win_count
);

  localparam int SW       = SAMPLE_FRAC_BITS + 3;
  localparam int AMP_W    = SAMPLE_FRAC_BITS + 2;
  localparam int RMS_W    = SAMPLE_FRAC_BITS + 1;
  localparam int MAG_W    = SAMPLE_FRAC_BITS + 1;
  localparam int PROD_W   = 2 * SAMPLE_FRAC_BITS + 1;
  localparam int SUM_FULL = 2 * SAMPLE_FRAC_BITS + COUNT_BITS;
  localparam int SUM_W    = (SUM_FULL > 64) ? 64 : SUM_FULL;
  localparam int ROOT_W   = (SUM_W + 1) / 2;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = (COUNT_BITS + 1 > ROOT_W + 3) ? COUNT_BITS + 1 : ROOT_W + 3;
  localparam int STEP_W   = $clog2(RAD_W + 1);
  localparam int IDX_W    = wmre_pkg::INDEX_BITS;
  localparam int ONE_INT  = 1 << SAMPLE_FRAC_BITS;

  localparam logic signed [SW-1:0]    POS_ONE_S = SW'(ONE_INT);
  localparam logic signed [SW-1:0]    NEG_ONE_S = -POS_ONE_S;
  localparam logic signed [AMP_W-1:0] POS_ONE_A = AMP_W'(ONE_INT);
  localparam logic signed [AMP_W-1:0] NEG_ONE_A = -POS_ONE_A;

  wmre_pkg::state_t          state_r, state_nxt;
  logic signed [AMP_W-1:0]   samp_r, samp_nxt;
  logic                      last_r, last_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic [COUNT_BITS-1:0]     win_len_r, win_len_nxt;
  logic [COUNT_BITS-1:0]     fill_r, fill_nxt;
  logic signed [AMP_W-1:0]   min_r, min_nxt;
  logic signed [AMP_W-1:0]   max_r, max_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [RAD_W-1:0]          rad_r, rad_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]          out_idx_r, out_idx_nxt;
  logic signed [AMP_W-1:0]   out_min_r, out_min_nxt;
  logic signed [AMP_W-1:0]   out_max_r, out_max_nxt;
  logic [RMS_W-1:0]          out_rms_r, out_rms_nxt;
  logic [COUNT_BITS-1:0]     out_cnt_r, out_cnt_nxt;

  logic signed [SW-1:0]      clamp_s;
  logic [MAG_W-1:0]          mag;
  logic [2*MAG_W-1:0]        prod_full;
  logic [COUNT_BITS-1:0]     len_eff;
  logic [COUNT_BITS-1:0]     fill_inc;
  logic [SUM_W-1:0]          sum_inc;
  logic                      close_win;
  wmre_pkg::op_t             u_op;
  logic [REM_W-1:0]          u_rem;
  logic                      u_ge;

  wmre_cmp_sub #(
    .COUNT_BITS(COUNT_BITS),
    .ROOT_BITS (ROOT_W),
    .REM_BITS  (REM_W)
  ) u_cmp_sub (
    .op      (u_op),
    .rem_in  (rem_r),
    .shift_in(rad_r[RAD_W-1:RAD_W-2]),
    .divisor (fill_r),
    .root    (root_r),
    .rem_out (u_rem),
    .ge      (u_ge)
  );

  assign u_op     = (state_r == wmre_pkg::ST_SQRT) ? wmre_pkg::OP_SQRT : wmre_pkg::OP_DIV;
  assign in_stall = (state_r != wmre_pkg::ST_IDLE);

  always_comb begin
    if (in_sample > POS_ONE_S) begin
      clamp_s = POS_ONE_S;
    end else if (in_sample < NEG_ONE_S) begin
      clamp_s = NEG_ONE_S;
    end else begin
      clamp_s = in_sample;
    end
    mag       = samp_r[AMP_W-1] ? MAG_W'(-samp_r) : MAG_W'(samp_r);
    prod_full = mag * mag;
    len_eff   = (win_len_r == '0) ? COUNT_BITS'(1) : win_len_r;
    fill_inc  = fill_r + COUNT_BITS'(1);
    sum_inc   = sum_r + SUM_W'(prod_r);
    close_win = (fill_inc >= len_eff) || last_r;
  end

  always_comb begin
    state_nxt     = state_r;
    samp_nxt      = samp_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    win_len_nxt   = cfg_write ? cfg_data : win_len_r;
    fill_nxt      = fill_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_rms_nxt   = out_rms_r;
    out_cnt_nxt   = out_cnt_r;

    unique case (state_r)
      wmre_pkg::ST_IDLE: begin
        if (in_valid) begin
          samp_nxt  = AMP_W'(clamp_s);
          last_nxt  = in_end_of_stream;
          state_nxt = wmre_pkg::ST_SQ;
        end
      end
      wmre_pkg::ST_SQ: begin
        prod_nxt  = PROD_W'(prod_full);
        state_nxt = wmre_pkg::ST_ACC;
      end
      wmre_pkg::ST_ACC: begin
        fill_nxt = fill_inc;
        sum_nxt  = sum_inc;
        if (samp_r < min_r) begin
          min_nxt = samp_r;
        end
        if (samp_r > max_r) begin
          max_nxt = samp_r;
        end
        if (close_win) begin
          rad_nxt   = RAD_W'(sum_inc);
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = wmre_pkg::ST_DIV;
        end else begin
          state_nxt = wmre_pkg::ST_IDLE;
        end
      end
      wmre_pkg::ST_DIV: begin
        rem_nxt  = u_rem;
        rad_nxt  = {rad_r[RAD_W-2:0], u_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(RAD_W - 1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = wmre_pkg::ST_SQRT;
        end
      end
      wmre_pkg::ST_SQRT: begin
        rem_nxt  = u_rem;
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        root_nxt = {root_r[ROOT_W-2:0], u_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = wmre_pkg::ST_FIN;
        end
      end
      wmre_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_min_nxt   = min_r;
          out_max_nxt   = max_r;
          out_rms_nxt   = root_r[RMS_W-1:0];
          out_cnt_nxt   = fill_r;
          idx_nxt       = last_r ? '0 : idx_r + IDX_W'(1);
          fill_nxt      = '0;
          min_nxt       = POS_ONE_A;
          max_nxt       = NEG_ONE_A;
          sum_nxt       = '0;
          state_nxt     = wmre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wmre_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wmre_pkg::ST_IDLE;
      win_len_r   <= COUNT_BITS'(wmre_pkg::WIN_LEN_RESET);
      fill_r      <= '0;
      min_r       <= POS_ONE_A;
      max_r       <= NEG_ONE_A;
      sum_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_len_r   <= win_len_nxt;
      fill_r      <= fill_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r    <= samp_nxt;
    last_r    <= last_nxt;
    prod_r    <= prod_nxt;
    rad_r     <= rad_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    step_r    <= step_nxt;
    out_idx_r <= out_idx_nxt;
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
    out_rms_r <= out_rms_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_window_index  = out_idx_r;
  assign out_min_amplitude = out_min_r;
  assign out_max_amplitude = out_max_r;
  assign out_rms_amplitude = out_rms_r;
  assign out_win_count     = out_cnt_r;

endmodule

`default_nettype wire

// ===== sv/wmre_checker.sv =====
// Port-level assertions for the envelope block, bound to the top level.
`default_nettype none

module wmre_checker #(
  parameter int COUNT_BITS       = 16,
  parameter int SAMPLE_FRAC_BITS = 15
) (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_stall,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic [wmre_pkg::INDEX_BITS-1:0]      out_window_index,
  input wire logic signed [SAMPLE_FRAC_BITS+1:0]   out_min_amplitude,
  input wire logic signed [SAMPLE_FRAC_BITS+1:0]   out_max_amplitude,
  input wire logic [SAMPLE_FRAC_BITS:0]            out_rms_amplitude,
  input wire logic [COUNT_BITS-1:0]                out_win_count
);

  localparam logic [SAMPLE_FRAC_BITS:0] RMS_ONE = (SAMPLE_FRAC_BITS + 1)'(1 << SAMPLE_FRAC_BITS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_window_index) &&
      $stable(out_rms_amplitude) && $stable(out_win_count))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while a sample is in work");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_amplitude <= out_max_amplitude) && (out_win_count != '0))
    else $error("window result with min above max or empty count");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rms_amplitude <= RMS_ONE)
    else $error("rms above full scale");

endmodule

bind waveform_min_max_rms_envelope wmre_checker #(
  .COUNT_BITS      (COUNT_BITS),
  .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
) u_wmre_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the min/max/RMS envelope block: directed and random streams against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W        = 16;
  localparam int FRAC_W       = 15;
  localparam int SAMP_W       = FRAC_W + 3;
  localparam int ONE          = 1 << FRAC_W;
  localparam int DRAIN_CYCLES = 10;
  localparam int TAIL_CYCLES  = 100;

  typedef struct packed {
    logic [wmre_pkg::INDEX_BITS-1:0] index;
    logic signed [FRAC_W+1:0]        amp_min;
    logic signed [FRAC_W+1:0]        amp_max;
    logic [FRAC_W:0]                 rms;
    logic [CNT_W-1:0]                count;
  } window_t;

  logic                            clk              = 1'b0;
  logic                            rst_n            = 1'b0;
  logic                            cfg_write        = 1'b0;
  logic [CNT_W-1:0]                cfg_data         = '0;
  logic                            in_valid         = 1'b0;
  logic                            in_stall;
  logic signed [FRAC_W+2:0]        in_sample        = '0;
  logic                            in_end_of_stream = 1'b0;
  logic                            out_valid;
  logic                            out_stall        = 1'b0;
  logic [wmre_pkg::INDEX_BITS-1:0] out_window_index;
  logic signed [FRAC_W+1:0]        out_min_amplitude;
  logic signed [FRAC_W+1:0]        out_max_amplitude;
  logic [FRAC_W:0]                 out_rms_amplitude;
  logic [CNT_W-1:0]                out_win_count;

  // predictor state
  logic [CNT_W-1:0]                len_reg;
  logic [CNT_W-1:0]                fill;
  int                              run_lo;
  int                              run_hi;
  longint unsigned                 sq_sum;
  logic [wmre_pkg::INDEX_BITS-1:0] win_idx;
  window_t                         window_q[$];

  int errors  = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_wait = 0;

  waveform_min_max_rms_envelope #(
    .COUNT_BITS      (CNT_W),
    .SAMPLE_FRAC_BITS(FRAC_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_window_index (out_window_index),
    .out_min_amplitude(out_min_amplitude),
    .out_max_amplitude(out_max_amplitude),
    .out_rms_amplitude(out_rms_amplitude),
    .out_win_count    (out_win_count)
  );

  always #10 clk = ~clk;

  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic clear_window();
    fill   = '0;
    run_lo = ONE;
    run_hi = -ONE;
    sq_sum = 0;
  endtask

  function automatic logic [FRAC_W:0] floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[FRAC_W:0];
  endfunction

  task automatic predict_window(input logic signed [FRAC_W+2:0] raw, input logic eos);
    int               v;
    longint unsigned  mag;
    longint unsigned  mean;
    logic [CNT_W-1:0] span;
    window_t          w;
    v = raw;
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    if (v < run_lo) run_lo = v;
    if (v > run_hi) run_hi = v;
    mag = 64'((v < 0) ? -v : v);
    sq_sum += mag * mag;
    fill = fill + 1'b1;
    span = (len_reg == '0) ? CNT_W'(1) : len_reg;
    if (fill < span && !eos) return;
    mean = (fill != '0) ? sq_sum / fill : 0;
    w.index   = win_idx;
    w.amp_min = run_lo[FRAC_W+1:0];
    w.amp_max = run_hi[FRAC_W+1:0];
    w.rms     = floor_sqrt(mean);
    w.count   = fill;
    window_q  = {window_q, w};
    win_idx = eos ? '0 : win_idx + 1'b1;
    clear_window();
  endtask

  task automatic send_sample(input int s, input logic eos);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample        <= SAMP_W'(s);
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    predict_window(SAMP_W'(s), eos);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [CNT_W-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    len_reg = v;
  endtask

  function automatic int random_sample();
    int t;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 6))
          0: return 131071;
          1: return -131072;
          2: return ONE;
          3: return -ONE;
          4: return ONE + 1;
          5: return -ONE - 1;
          default: return 0;
        endcase
      end
      default: begin
        t = $urandom_range(0, 2 * ONE);
        return t - ONE;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : rx_check
    window_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (window_q.size() == 0) begin
        $error("unexpected window result, index %0d", out_window_index);
        errors++;
      end else begin
        w = window_q.pop_front();
        check_field("window_index", longint'(w.index), longint'(out_window_index));
        check_field("min_amplitude", longint'(w.amp_min), longint'(out_min_amplitude));
        check_field("max_amplitude", longint'(w.amp_max), longint'(out_max_amplitude));
        check_field("rms_amplitude", longint'(w.rms), longint'(out_rms_amplitude));
        check_field("win_count", longint'(w.count), longint'(out_win_count));
      end
      rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
    end else if (out_valid && rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait > 0);
  end

  task automatic test_clamp_extremes();
    send_sample(131071, 1'b0);
    send_sample(-131072, 1'b0);
    send_sample(ONE, 1'b0);
    send_sample(ONE + 1, 1'b0);
    send_sample(-ONE, 1'b0);
    send_sample(-ONE - 1, 1'b0);
    send_sample(ONE - 1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(12345, 1'b1);
    send_sample(-5, 1'b1);
  endtask

  task automatic test_zero_length();
    write_length('0);
    send_sample(100, 1'b0);
    send_sample(-200, 1'b0);
    send_sample(300, 1'b0);
    send_sample(7, 1'b1);
    send_sample(-9, 1'b0);
  endtask

  task automatic test_length_shrink();
    write_length(10);
    for (int i = 0; i < 6; i++) send_sample(random_sample(), 1'b0);
    write_length(4);
    send_sample(random_sample(), 1'b0);
  endtask

  task automatic test_long_window();
    write_length(16'hFFFF);
    send_sample(ONE - 1, 1'b0);
    send_sample(-ONE, 1'b0);
    send_sample(1, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [CNT_W-1:0] lengths [9];
    logic [CNT_W-1:0] span;
    int               eos_rate;
    lengths = '{1, 0, 16'hFFFF, 2, 200, 3, 16, 5, 16'hFFFF};
    for (int p = 0; p < 12; p++) begin
      span = (p < 9) ? lengths[p] : CNT_W'($urandom_range(1, 40));
      write_length(span);
      tx_idle  = (p % 3) != 1;
      rx_idle  = (p % 4) != 2;
      eos_rate = (span > 64) ? 12 : 40;
      for (int i = 0; i < 155; i++) begin
        send_sample(random_sample(), $urandom_range(0, eos_rate - 1) == 0);
      end
    end
  endtask

  initial begin
    len_reg = CNT_W'(wmre_pkg::WIN_LEN_RESET);
    win_idx = '0;
    clear_window();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_clamp_extremes();
    test_zero_length();
    test_length_shrink();
    test_long_window();
    test_random_streams();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && window_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wmre_pkg.sv
sv/wmre_cmp_sub.sv
sv/waveform_min_max_rms_envelope.sv
sv/wmre_checker.sv
sim/tb_top.sv
